[src/sed_pkg.sv]
package sed_pkg;

  // Input beat: one audio sample, one millisecond tick or a turn start.
  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] sample;
    logic               last_in_chunk;
  } in_item_t;

  // Result beat: chunk evaluation plus the turn status after the item.
  typedef struct packed {
    logic        chunk_done;
    logic [15:0] peak_amplitude;
    logic        voice_seen;
    logic        stopped;
    logic [1:0]  stop_reason;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PEAK,
    ST_DECIDE
  } seq_state_t;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Action codes.
  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;

  // Stop reasons.
  localparam logic [1:0] STOP_NONE    = 2'd0;
  localparam logic [1:0] STOP_SILENCE = 2'd1;
  localparam logic [1:0] STOP_NOVOICE = 2'd2;
  localparam logic [1:0] STOP_MAXTIME = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [1:0] REG_END_SIL     = 2'd1;
  localparam logic [1:0] REG_INIT_SIL    = 2'd2;
  localparam logic [1:0] REG_MAX_RECORD  = 2'd3;

  // Configuration reset values.
  localparam logic [15:0] THRESHOLD_RST  = 16'd600;
  localparam logic [15:0] END_SIL_RST    = 16'd1000;
  localparam logic [15:0] INIT_SIL_RST   = 16'd5000;
  localparam logic [15:0] MAX_RECORD_RST = 16'd15000;

  // Chunk extreme trackers start at the opposite ends of the sample range.
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;

  localparam logic [15:0] TIMER_SAT = 16'hFFFF;

endpackage

[src/sed_divider.sv]
module sed_divider
  import sed_pkg::*;
#(
  parameter int DVD_W = 26,
  parameter int DVS_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output div_stat_t        stat
);

  localparam int ITER_W = $clog2(DVD_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    diff;

  // One restoring step a cycle: shift in the next dividend bit, try a subtract.
  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      iter_nxt = ITER_W'(DVD_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[DVS_W]) begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      iter_nxt = iter_r - ITER_W'(1);
      if (iter_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[src/speech_endpoint_detector_unit.sv]
// Energy based speech endpoint detector.
// The input channel (in_valid/in_ready/in_data) carries one beat per audio
// sample, per one millisecond tick or per turn start. Every accepted beat
// gives exactly one result beat on out_valid/out_ready/out_data with the
// turn status after that beat; a beat that closes a chunk also carries the
// chunk's peak deviation from its mean.
// A tick, a start or a sample that leaves its chunk open returns its
// result in the cycle after acceptance, and the next beat can be taken in
// that same cycle if the receiver is ready. A sample that closes a chunk
// runs the restoring divider for the mean, one quotient bit a cycle, then
// passes through the peak and decide states; in_ready is low meanwhile.
// Configuration writes on cfg_we/cfg_index/cfg_wdata take effect at once;
// the user must make them while the block is idle; the block does not enforce it.
// Reset (synchronous, active low) loads the default limits and leaves the
// block stopped until a start beat arrives. A stalled receiver holds the
// result in the output register; one more beat can be taken meanwhile only
// once that register frees up.
module speech_endpoint_detector_unit
  import sed_pkg::*;
#(
  parameter int MAX_CHUNK_SAMPLES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_CHUNK_SAMPLES + 1);
  localparam int SUM_W = 16 + CNT_W;

  // Configuration.
  logic [15:0] thr_r, end_sil_r, init_sil_r, max_rec_r;

  // Chunk and turn state.
  seq_state_t         state_r, state_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic signed [15:0] max_r, max_nxt;
  logic signed [15:0] min_r, min_nxt;
  logic               spoken_r, spoken_nxt;
  logic [15:0]        sil_r, sil_nxt;
  logic [15:0]        rec_r, rec_nxt;
  logic               stopped_r, stopped_nxt;
  logic [1:0]         code_r, code_nxt;
  logic               neg_r, neg_nxt;
  logic [15:0]        peak_r, peak_nxt;

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // Divider hookup.
  logic             div_start;
  logic [SUM_W-1:0] div_dvd;
  logic [SUM_W-1:0] div_quo;
  div_stat_t        div_stat;

  logic in_fire, out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  sed_divider #(
    .DVD_W(SUM_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (cnt_nxt),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THRESHOLD_RST;
      end_sil_r  <= END_SIL_RST;
      init_sil_r <= INIT_SIL_RST;
      max_rec_r  <= MAX_RECORD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:  thr_r      <= cfg_wdata;
        REG_END_SIL:    end_sil_r  <= cfg_wdata;
        REG_INIT_SIL:   init_sil_r <= cfg_wdata;
        REG_MAX_RECORD: max_rec_r  <= cfg_wdata;
        default:        thr_r      <= thr_r;
      endcase
    end
  end

  // Sequencer: beat handling, chunk evaluation and the turn status.
  always_comb begin
    logic signed [15:0] s;
    logic [SUM_W-1:0]   s_ext;
    logic [SUM_W-1:0]   sum_add;
    logic [16:0]        q_mag;
    logic signed [17:0] dc, up, down, pk;
    logic               res_load;
    logic               res_chunk;

    s         = in_data.sample;
    s_ext     = {{(SUM_W-16){s[15]}}, s};
    sum_add   = sum_r + s_ext;
    q_mag     = div_quo[16:0];
    dc        = neg_r ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    up        = $signed({{2{max_r[15]}}, max_r}) - dc;
    down      = dc - $signed({{2{min_r[15]}}, min_r});
    pk        = (up > down) ? up : down;
    res_load  = 1'b0;
    res_chunk = 1'b0;

    state_nxt   = state_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    max_nxt     = max_r;
    min_nxt     = min_r;
    spoken_nxt  = spoken_r;
    sil_nxt     = sil_r;
    rec_nxt     = rec_r;
    stopped_nxt = stopped_r;
    code_nxt    = code_r;
    neg_nxt     = neg_r;
    peak_nxt    = peak_r;
    div_start   = 1'b0;
    div_dvd     = sum_add[SUM_W-1] ? -sum_add : sum_add;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_load = 1'b1;
          case (in_data.action)
            ACT_START: begin
              sum_nxt     = '0;
              cnt_nxt     = '0;
              max_nxt     = SAMPLE_MIN;
              min_nxt     = SAMPLE_MAX;
              spoken_nxt  = 1'b0;
              sil_nxt     = '0;
              rec_nxt     = '0;
              stopped_nxt = 1'b0;
              code_nxt    = STOP_NONE;
            end
            ACT_TICK: begin
              if (!stopped_r) begin
                sil_nxt = (sil_r == TIMER_SAT) ? sil_r : sil_r + 16'd1;
                rec_nxt = (rec_r == TIMER_SAT) ? rec_r : rec_r + 16'd1;
                if (rec_nxt > max_rec_r) begin
                  stopped_nxt = 1'b1;
                  code_nxt    = STOP_MAXTIME;
                  sum_nxt     = '0;
                  cnt_nxt     = '0;
                  max_nxt     = SAMPLE_MIN;
                  min_nxt     = SAMPLE_MAX;
                end
              end
            end
            ACT_SAMPLE: begin
              if (!stopped_r) begin
                sum_nxt = sum_add;
                cnt_nxt = cnt_r + CNT_W'(1);
                if (s > max_r) max_nxt = s;
                if (s < min_r) min_nxt = s;
                // A closing sample hands the mean to the divider.
                if (in_data.last_in_chunk || cnt_nxt >= CNT_W'(MAX_CHUNK_SAMPLES)) begin
                  res_load  = 1'b0;
                  div_start = 1'b1;
                  neg_nxt   = sum_add[SUM_W-1];
                  state_nxt = ST_DIV;
                end
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      ST_DIV: begin
        if (div_stat.done) state_nxt = ST_PEAK;
      end
      ST_PEAK: begin
        peak_nxt  = pk[17] ? 16'd0 : pk[15:0];
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) begin
          res_load  = 1'b1;
          res_chunk = 1'b1;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          max_nxt   = SAMPLE_MIN;
          min_nxt   = SAMPLE_MAX;
          if (peak_r > thr_r) begin
            spoken_nxt = 1'b1;
            sil_nxt    = '0;
          end else if (spoken_r && sil_r > end_sil_r) begin
            stopped_nxt = 1'b1;
            code_nxt    = STOP_SILENCE;
          end else if (!spoken_r && sil_r > init_sil_r) begin
            stopped_nxt = 1'b1;
            code_nxt    = STOP_NOVOICE;
          end
          if (!stopped_nxt && rec_r > max_rec_r) begin
            stopped_nxt = 1'b1;
            code_nxt    = STOP_MAXTIME;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Result beat built from the state after the item.
    out_data_nxt                = out_data_r;
    if (res_load) begin
      out_data_nxt.chunk_done     = res_chunk;
      out_data_nxt.peak_amplitude = res_chunk ? peak_r : 16'd0;
      out_data_nxt.voice_seen     = spoken_nxt;
      out_data_nxt.stopped        = stopped_nxt;
      out_data_nxt.stop_reason    = code_nxt;
    end
    out_valid_nxt = res_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      max_r       <= SAMPLE_MIN;
      min_r       <= SAMPLE_MAX;
      spoken_r    <= 1'b0;
      sil_r       <= '0;
      rec_r       <= '0;
      stopped_r   <= 1'b1;
      code_r      <= STOP_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      max_r       <= max_nxt;
      min_r       <= min_nxt;
      spoken_r    <= spoken_nxt;
      sil_r       <= sil_nxt;
      rec_r       <= rec_nxt;
      stopped_r   <= stopped_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r      <= neg_nxt;
    peak_r     <= peak_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  // Starting the divider always moves the sequencer into the divide state.
  a_start_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == ST_DIV && div_stat.busy))
    else $error("divider start without divide state");

  // A result without a closed chunk carries no peak.
  a_peak_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.chunk_done) |-> out_data.peak_amplitude == 16'd0)
    else $error("peak reported without a closed chunk");

  // A running turn reports no stop reason.
  a_running_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.stopped) |-> out_data.stop_reason == STOP_NONE)
    else $error("stop reason set on a running turn");
`endif

endmodule
